// File: hw/rtl/tmwp_pkg.sv
// ----------------------------------------------------------------------------
// tmwp_pkg
// Shared constants, action codes and controller/datapath interface types for
// the text marquee word packer.
// ----------------------------------------------------------------------------
package tmwp_pkg;

  localparam int unsigned TextDepthDefault = 1024;
  localparam int unsigned WindowLen        = 6;
  localparam int unsigned CharW            = 8;
  localparam int unsigned LenRegW          = 11;
  localparam int unsigned AddrFieldW       = 10;
  localparam int unsigned ActionW          = 2;
  localparam logic [CharW-1:0] SpaceChar   = 8'h20;
  localparam logic [LenRegW-1:0] LenReset  = 11'd6;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK     = 2'd0,
    ACT_TOGGLE   = 2'd1,
    ACT_ACTIVATE = 2'd2,
    ACT_LOAD     = 2'd3
  } action_e;

  typedef struct packed {
    logic load;
    logic toggle;
    logic activate;
    logic char_step;
    logic commit_adv;
    logic start;
    logic word_step;
    logic fill_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic words_on;
    logic word_done;
    logic char_done;
  } dp_status_t;

endpackage

// File: hw/rtl/text_marquee_word_packer.sv
// ----------------------------------------------------------------------------
// text_marquee_word_packer
// Scrolls a loaded message through a six-character window, by character or by
// greedily packed whole words.
// A load transfer completes in its accept cycle and gives no result. Other
// actions fill the window one stored character per cycle (word mode: a tick
// scans twice, advance pass from the old offset, then fill pass), and then
// ST_DELIVER registers the result once the output register is free.
// Throughput is one item at a time; an item is taken while a result waits.
// Reset sets length 6, offset 0 and character mode; the text store is kept.
// ----------------------------------------------------------------------------
module text_marquee_word_packer #(
  parameter int unsigned TEXT_DEPTH = tmwp_pkg::TextDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic [tmwp_pkg::LenRegW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tmwp_pkg::ActionW-1:0]        action_i,
  input  logic [tmwp_pkg::AddrFieldW-1:0]     load_address_i,
  input  logic [tmwp_pkg::CharW-1:0]          load_char_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tmwp_pkg::CharW-1:0]          shown_char0_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char1_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char2_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char3_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char4_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char5_o,
  output logic                                in_word_mode_o,
  output logic [tmwp_pkg::AddrFieldW-1:0]     window_start_o
);
  import tmwp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tmwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tmwp_datapath #(
    .TextDepth (TEXT_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_write_i),
    .cfg_data_i     (cfg_data_i),
    .load_address_i (load_address_i),
    .load_char_i    (load_char_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .shown_char0_o  (shown_char0_o),
    .shown_char1_o  (shown_char1_o),
    .shown_char2_o  (shown_char2_o),
    .shown_char3_o  (shown_char3_o),
    .shown_char4_o  (shown_char4_o),
    .shown_char5_o  (shown_char5_o),
    .in_word_mode_o (in_word_mode_o),
    .window_start_o (window_start_o)
  );

  // A tick, toggle or activate transfer keeps the block busy in the next cycle.
  a_busy_after_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i != ACT_LOAD) |=> !in_ready_o)
    else $error("block ready right after a display action");

  // A load transfer is finished in its own cycle.
  a_load_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_LOAD) |=> in_ready_o)
    else $error("block busy after a load");

  // Activate always returns to character mode.
  a_activate_char_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_ACTIVATE) |=> !status.words_on)
    else $error("word mode still set after activate");

endmodule

// File: hw/rtl/tmwp_datapath.sv
// ----------------------------------------------------------------------------
// tmwp_datapath
// Text store, scroll offset, mode flag and the scan engine that fills the
// six-character window one stored character per cycle.
// ----------------------------------------------------------------------------
module tmwp_datapath #(
  parameter int unsigned TextDepth = tmwp_pkg::TextDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic [tmwp_pkg::LenRegW-1:0]        cfg_data_i,
  input  logic [tmwp_pkg::AddrFieldW-1:0]     load_address_i,
  input  logic [tmwp_pkg::CharW-1:0]          load_char_i,
  input  tmwp_pkg::ctrl_cmd_t                 cmd_i,
  output tmwp_pkg::dp_status_t                status_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char0_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char1_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char2_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char3_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char4_o,
  output logic [tmwp_pkg::CharW-1:0]          shown_char5_o,
  output logic                                in_word_mode_o,
  output logic [tmwp_pkg::AddrFieldW-1:0]     window_start_o
);
  import tmwp_pkg::*;

  localparam int unsigned AW = $clog2(TextDepth);
  localparam int unsigned LW = $clog2(TextDepth + 1);
  localparam int unsigned IW = $clog2(TextDepth + WindowLen);

  logic [CharW-1:0]   mem [TextDepth];
  logic [CharW-1:0]   rd_q;
  logic [AW-1:0]      rd_addr;
  logic               load_ok;

  logic [LenRegW-1:0] len_q;
  logic [LW-1:0]      eff_len;
  logic [LW-1:0]      limit;
  logic [LW-1:0]      nxt;
  logic [AW-1:0]      char_next;

  logic               mode_q, mode_d;
  logic [AW-1:0]      off_q, off_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic               phase_q, phase_d;
  logic [2:0]         used_q, used_d;
  logic [2:0]         wl_q, wl_d;
  logic [AW-1:0]      wstart_q, wstart_d;
  logic [2:0]         k_q, k_d;
  logic [CharW-1:0]   win_q [WindowLen];
  logic [CharW-1:0]   win_d [WindowLen];
  logic [CharW-1:0]   shown_q [WindowLen];
  logic               shown_mode_q;
  logic [AW-1:0]      shown_off_q;

  logic               at_end;
  logic               is_space;
  logic [3:0]         fit_sum;
  logic [3:0]         pos;
  logic               fits;
  logic               word_done;
  logic               brk;

  assign load_ok = 32'(load_address_i) < 32'(TextDepth);
  assign eff_len = (32'(len_q) > 32'(TextDepth)) ? LW'(TextDepth) : LW'(len_q);
  assign limit   = (eff_len >= LW'(WindowLen)) ? eff_len - LW'(WindowLen) : '0;
  assign nxt     = LW'(off_q) + LW'(1);
  assign char_next = (nxt > limit) ? '0 : AW'(nxt);

  assign at_end   = idx_q >= IW'(eff_len);
  assign is_space = rd_q == SpaceChar;
  assign fit_sum  = 4'(used_q) + 4'd1 + 4'(wl_q);
  assign pos      = (used_q == 3'd0) ? 4'(wl_q) : fit_sum;
  assign fits     = (used_q == 3'd0) || (fit_sum <= 4'(WindowLen));

  always_comb begin
    mode_d    = mode_q;
    off_d     = off_q;
    idx_d     = idx_q;
    phase_d   = phase_q;
    used_d    = used_q;
    wl_d      = wl_q;
    wstart_d  = wstart_q;
    k_d       = k_q;
    win_d     = win_q;
    word_done = 1'b0;
    brk       = 1'b0;

    if (cmd_i.toggle) begin
      mode_d = ~mode_q;
      off_d  = '0;
    end
    if (cmd_i.activate) begin
      mode_d = 1'b0;
      off_d  = '0;
    end
    if (cmd_i.char_step) begin
      off_d = char_next;
    end

    if (cmd_i.word_step) begin
      if (!phase_q) begin
        if (at_end) begin
          word_done = 1'b1;
        end else if (is_space) begin
          idx_d = idx_q + IW'(1);
        end else begin
          wstart_d = idx_q[AW-1:0];
          phase_d  = 1'b1;
          for (int j = 0; j < WindowLen; j++) begin
            if (pos == 4'(j)) begin
              win_d[j] = rd_q;
            end
          end
          wl_d  = (wl_q == 3'd7) ? wl_q : wl_q + 3'd1;
          idx_d = idx_q + IW'(1);
        end
      end else if (at_end || is_space) begin
        wl_d    = '0;
        phase_d = 1'b0;
        if (!fits) begin
          word_done = 1'b1;
          brk       = 1'b1;
          for (int j = 0; j < WindowLen; j++) begin
            if (3'(j) >= used_q) begin
              win_d[j] = SpaceChar;
            end
          end
        end else begin
          if (used_q == 3'd0) begin
            used_d = (wl_q > 3'(WindowLen)) ? 3'(WindowLen) : wl_q;
          end else begin
            used_d = 3'(fit_sum);
          end
          if (at_end) begin
            word_done = 1'b1;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end else begin
        for (int j = 0; j < WindowLen; j++) begin
          if (pos == 4'(j)) begin
            win_d[j] = rd_q;
          end
        end
        wl_d  = (wl_q == 3'd7) ? wl_q : wl_q + 3'd1;
        idx_d = idx_q + IW'(1);
      end
    end

    if (cmd_i.fill_step) begin
      for (int j = 0; j < WindowLen; j++) begin
        if (k_q == 3'(j)) begin
          win_d[j] = at_end ? SpaceChar : rd_q;
        end
      end
      k_d   = k_q + 3'd1;
      idx_d = idx_q + IW'(1);
    end

    if (cmd_i.commit_adv) begin
      off_d = brk ? wstart_q : '0;
    end

    if (cmd_i.start) begin
      idx_d   = IW'(off_d);
      phase_d = 1'b0;
      used_d  = '0;
      wl_d    = '0;
      k_d     = '0;
      for (int j = 0; j < WindowLen; j++) begin
        win_d[j] = SpaceChar;
      end
    end
  end

  assign rd_addr = idx_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem[AW'(load_address_i)] <= load_char_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenReset;
      mode_q <= 1'b0;
      off_q  <= '0;
    end else begin
      if (cfg_write_i) begin
        len_q <= cfg_data_i;
      end
      mode_q <= mode_d;
      off_q  <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    phase_q  <= phase_d;
    used_q   <= used_d;
    wl_q     <= wl_d;
    wstart_q <= wstart_d;
    k_q      <= k_d;
    win_q    <= win_d;
    if (cmd_i.out_load) begin
      shown_q      <= win_d;
      shown_mode_q <= mode_q;
      shown_off_q  <= off_q;
    end
  end

  assign status_o.words_on  = mode_q;
  assign status_o.word_done = word_done;
  assign status_o.char_done = k_q == 3'(WindowLen - 1);

  assign shown_char0_o  = shown_q[0];
  assign shown_char1_o  = shown_q[1];
  assign shown_char2_o  = shown_q[2];
  assign shown_char3_o  = shown_q[3];
  assign shown_char4_o  = shown_q[4];
  assign shown_char5_o  = shown_q[5];
  assign in_word_mode_o = shown_mode_q;
  assign window_start_o = AddrFieldW'(shown_off_q);

endmodule

// File: hw/rtl/tmwp_ctrl.sv
// ----------------------------------------------------------------------------
// tmwp_ctrl
// Sequencer for the marquee: decodes actions, steps the scan engine through
// advance and fill passes, and hands finished windows to the output register.
// ----------------------------------------------------------------------------
module tmwp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [tmwp_pkg::ActionW-1:0]  action_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  input  tmwp_pkg::dp_status_t          status_i,
  output tmwp_pkg::ctrl_cmd_t           cmd_o
);
  import tmwp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ADV     = 5'b00010,
    ST_WFILL   = 5'b00100,
    ST_CFILL   = 5'b01000,
    ST_DELIVER = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  action_e action;

  assign action = action_e'(action_i);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action)
            ACT_LOAD: begin
              cmd_o.load = 1'b1;
            end
            ACT_TICK: begin
              cmd_o.start = 1'b1;
              if (status_i.words_on) begin
                state_d = ST_ADV;
              end else begin
                cmd_o.char_step = 1'b1;
                state_d         = ST_CFILL;
              end
            end
            ACT_TOGGLE: begin
              cmd_o.toggle = 1'b1;
              cmd_o.start  = 1'b1;
              state_d      = status_i.words_on ? ST_CFILL : ST_WFILL;
            end
            ACT_ACTIVATE: begin
              cmd_o.activate = 1'b1;
              cmd_o.start    = 1'b1;
              state_d        = ST_CFILL;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADV: begin
        cmd_o.word_step = 1'b1;
        if (status_i.word_done) begin
          cmd_o.commit_adv = 1'b1;
          cmd_o.start      = 1'b1;
          state_d          = ST_WFILL;
        end
      end
      ST_WFILL: begin
        cmd_o.word_step = 1'b1;
        if (status_i.word_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_CFILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.char_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: test/text_marquee_word_packer_tb.sv
// ----------------------------------------------------------------------------
// text_marquee_word_packer_tb
// Loads messages into the text store, scrolls them by character and by packed
// words under several message lengths, and compares every display window
// against a cycle-free predictor of the marquee, with random idle gaps on the
// input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_marquee_word_packer_tb;
  import tmwp_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned NumPhases    = 14;

  typedef struct packed {
    logic [WindowLen-1:0][CharW-1:0] chars;
    logic                            words_on;
    logic [AddrFieldW-1:0]           start;
  } window_t;

  typedef enum int unsigned {
    TEXT_WORDS,
    TEXT_NOISE,
    TEXT_LONG_WORDS,
    TEXT_SPARSE
  } text_style_e;

  class marquee_window_scoreboard;
    logic [CharW-1:0] text [TextDepthDefault];
    int unsigned      offset;
    bit               words_on;
    int unsigned      msg_len;
    window_t          pending_windows [$];
    int unsigned      errors;

    function new();
      offset   = 0;
      words_on = 1'b0;
      msg_len  = LenReset;
      errors   = 0;
    endfunction

    function void set_length(int unsigned value);
      msg_len = value;
    endfunction

    function int unsigned pending();
      return pending_windows.size();
    endfunction

    function int unsigned skip_spaces(int unsigned idx, int unsigned len);
      while (idx < len && text[idx] == SpaceChar) idx++;
      return idx;
    endfunction

    function int unsigned word_len_at(int unsigned idx, int unsigned len);
      int unsigned n;
      n = 0;
      while (idx + n < len && text[idx + n] != SpaceChar) n++;
      return n;
    endfunction

    function void advance_words(int unsigned len);
      int unsigned idx, used, wl;
      idx  = skip_spaces(offset, len);
      used = 0;
      while (idx < len) begin
        wl = word_len_at(idx, len);
        if (used != 0 && used + 1 + wl > WindowLen) break;
        idx  += wl;
        used += wl + ((used != 0) ? 1 : 0);
        idx   = skip_spaces(idx, len);
      end
      offset = (idx >= len) ? 0 : idx;
    endfunction

    function void advance_chars(int unsigned len);
      int unsigned limit;
      limit = (len >= WindowLen) ? len - WindowLen : 0;
      offset++;
      if (offset > limit) offset = 0;
    endfunction

    function window_t compose(int unsigned len);
      window_t     w;
      int unsigned idx, used, wl, first, i;
      w.words_on = words_on;
      w.start    = offset[AddrFieldW-1:0];
      for (i = 0; i < WindowLen; i++) w.chars[i] = SpaceChar;
      if (!words_on) begin
        for (i = 0; i < WindowLen; i++) begin
          if (offset + i < len) w.chars[i] = text[offset + i];
        end
      end else begin
        idx  = skip_spaces(offset, len);
        used = 0;
        while (idx < len) begin
          first = idx;
          wl    = word_len_at(idx, len);
          idx  += wl;
          if (used != 0 && used + 1 + wl > WindowLen) break;
          if (wl > WindowLen) wl = WindowLen;
          if (used != 0) begin
            w.chars[used] = SpaceChar;
            used++;
          end
          for (i = 0; i < wl && used < WindowLen; i++) begin
            w.chars[used] = text[first + i];
            used++;
          end
          idx = skip_spaces(idx, len);
        end
      end
      return w;
    endfunction

    function void note_transfer(action_e act, logic [AddrFieldW-1:0] addr,
                                logic [CharW-1:0] ch);
      int unsigned len;
      len = (msg_len > TextDepthDefault) ? TextDepthDefault : msg_len;
      case (act)
        ACT_LOAD: begin
          text[addr] = ch;
        end
        ACT_TICK: begin
          if (words_on) advance_words(len);
          else advance_chars(len);
        end
        ACT_TOGGLE: begin
          words_on = !words_on;
          offset   = 0;
        end
        default: begin
          words_on = 1'b0;
          offset   = 0;
        end
      endcase
      if (act != ACT_LOAD) pending_windows.push_back(compose(len));
    endfunction

    function void check_window(window_t got);
      window_t want;
      int      i;
      if (pending_windows.size() == 0) begin
        $error("result transfer with no window pending");
        errors++;
      end else begin
        want = pending_windows.pop_front();
        for (i = 0; i < WindowLen; i++) begin
          if (got.chars[i] !== want.chars[i]) begin
            $error("shown_char%0d: expected %02h, actual %02h", i, want.chars[i],
                   got.chars[i]);
            errors++;
          end
        end
        if (got.words_on !== want.words_on) begin
          $error("in_word_mode: expected %0d, actual %0d", want.words_on, got.words_on);
          errors++;
        end
        if (got.start !== want.start) begin
          $error("window_start: expected %0d, actual %0d", want.start, got.start);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_write_i;
  logic [LenRegW-1:0]    cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ActionW-1:0]    action_i;
  logic [AddrFieldW-1:0] load_address_i;
  logic [CharW-1:0]      load_char_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CharW-1:0]      shown_char0_o;
  logic [CharW-1:0]      shown_char1_o;
  logic [CharW-1:0]      shown_char2_o;
  logic [CharW-1:0]      shown_char3_o;
  logic [CharW-1:0]      shown_char4_o;
  logic [CharW-1:0]      shown_char5_o;
  logic                  in_word_mode_o;
  logic [AddrFieldW-1:0] window_start_o;

  marquee_window_scoreboard window_board = new();
  bit                       written [TextDepthDefault];
  bit                       steady = 1'b0;

  text_marquee_word_packer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_write_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .load_address_i (load_address_i),
    .load_char_i    (load_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shown_char0_o  (shown_char0_o),
    .shown_char1_o  (shown_char1_o),
    .shown_char2_o  (shown_char2_o),
    .shown_char3_o  (shown_char3_o),
    .shown_char4_o  (shown_char4_o),
    .shown_char5_o  (shown_char5_o),
    .in_word_mode_o (in_word_mode_o),
    .window_start_o (window_start_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic send_item(action_e act, logic [AddrFieldW-1:0] addr,
                           logic [CharW-1:0] ch);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    load_address_i <= addr;
    load_char_i    <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    window_board.note_transfer(act, addr, ch);
    if (act == ACT_LOAD) written[addr] = 1'b1;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (window_board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LenRegW-1:0] value);
    settle();
    cfg_write_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_write_i <= 1'b0;
    window_board.set_length(value);
  endtask

  // Rewrites the head of the message and fills every entry below the length
  // that has not been written yet, so that no scan reaches an unwritten entry.
  task automatic write_text(text_style_e style, int unsigned upto);
    int unsigned      pos, run, r;
    bit               in_word;
    logic [CharW-1:0] ch;
    in_word = 1'($urandom_range(1));
    run     = 0;
    for (pos = 0; pos < upto; pos++) begin
      if (style == TEXT_NOISE) begin
        ch = 8'($urandom_range(255));
      end else begin
        if (run == 0) begin
          in_word = !in_word;
          if (in_word) run = (style == TEXT_LONG_WORDS) ? $urandom_range(24, 5)
                                                        : $urandom_range(8, 1);
          else run = (style == TEXT_SPARSE) ? $urandom_range(12, 1) : $urandom_range(2, 1);
        end
        run--;
        if (!in_word) begin
          ch = SpaceChar;
        end else if ($urandom_range(7) == 0) begin
          r  = $urandom_range(255);
          ch = (r == SpaceChar) ? 8'h00 : r[CharW-1:0];
        end else begin
          ch = 8'(8'h61 + $urandom_range(25));
        end
      end
      if (pos < 16 || !written[pos]) send_item(ACT_LOAD, pos[AddrFieldW-1:0], ch);
    end
  endtask

  task automatic run_phase(int unsigned count, int unsigned eff);
    int unsigned      r, addr;
    logic [CharW-1:0] ch;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 18) begin
        addr = ($urandom_range(3) == 0 || eff == 0) ? $urandom_range(TextDepthDefault - 1)
                                                    : $urandom_range(eff - 1);
        r    = $urandom_range(99);
        if (r < 40) ch = 8'(8'h61 + $urandom_range(25));
        else if (r < 75) ch = SpaceChar;
        else ch = 8'($urandom_range(255));
        send_item(ACT_LOAD, addr[AddrFieldW-1:0], ch);
      end else if (r < 80) begin
        send_item(ACT_TICK, 10'($urandom_range(1023)), 8'($urandom_range(255)));
      end else if (r < 90) begin
        send_item(ACT_TOGGLE, 10'($urandom_range(1023)), 8'($urandom_range(255)));
      end else begin
        send_item(ACT_ACTIVATE, 10'($urandom_range(1023)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    window_t     got;
    out_ready_i <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.chars[0] = shown_char0_o;
        got.chars[1] = shown_char1_o;
        got.chars[2] = shown_char2_o;
        got.chars[3] = shown_char3_o;
        got.chars[4] = shown_char4_o;
        got.chars[5] = shown_char5_o;
        got.words_on = in_word_mode_o;
        got.start    = window_start_o;
        window_board.check_window(got);
      end
      if (hold != 0) hold--;
      else hold = idle_cycles();
      out_ready_i <= (hold == 0);
    end
  end

  initial begin : stimulus
    logic [LenRegW-1:0] lengths [NumPhases];
    int unsigned        p, eff;
    rst_ni         <= 1'b0;
    cfg_write_i    <= 1'b0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_TICK;
    load_address_i <= '0;
    load_char_i    <= '0;
    lengths = '{11'd7, 11'd12, 11'd0, 11'd5, 11'd6, 11'd9, 11'd20, 11'd31, 11'd64,
                11'd1024, 11'd2047, 11'd17, 11'd8, 11'd40};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A two-byte first word made of a zero byte and an all-ones byte.
    send_item(ACT_LOAD, 10'd0, 8'h00);
    send_item(ACT_LOAD, 10'd1, 8'hFF);
    send_item(ACT_LOAD, 10'd2, SpaceChar);
    send_item(ACT_LOAD, 10'd3, 8'h71);
    send_item(ACT_LOAD, 10'd4, SpaceChar);
    send_item(ACT_LOAD, 10'd5, SpaceChar);
    send_item(ACT_LOAD, 10'h3FF, 8'hFF);
    send_item(ACT_TICK, 10'h3FF, 8'hFF);
    send_item(ACT_TICK, 10'd0, 8'h00);
    send_item(ACT_TOGGLE, 10'd0, 8'h00);
    send_item(ACT_TICK, 10'd0, 8'h00);
    send_item(ACT_TICK, 10'd0, 8'h00);
    send_item(ACT_ACTIVATE, 10'd0, 8'h00);
    send_item(ACT_TOGGLE, 10'd0, 8'h00);
    send_item(ACT_TOGGLE, 10'd0, 8'h00);
    write_length(11'd0);
    send_item(ACT_TICK, 10'd0, 8'h00);
    send_item(ACT_TOGGLE, 10'd0, 8'h00);
    send_item(ACT_TICK, 10'd0, 8'h00);
    send_item(ACT_ACTIVATE, 10'd0, 8'h00);

    for (p = 0; p < NumPhases; p++) begin
      steady = (p % 4 == 3);
      write_length(lengths[p]);
      eff = (lengths[p] > TextDepthDefault) ? TextDepthDefault : lengths[p];
      write_text(text_style_e'($urandom_range(3)), eff);
      run_phase((eff >= TextDepthDefault) ? 30 : 18, eff);
    end

    steady = 1'b0;
    settle();
    if (window_board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(60_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: text_marquee_word_packer.f
hw/rtl/tmwp_pkg.sv
hw/rtl/tmwp_datapath.sv
hw/rtl/tmwp_ctrl.sv
hw/rtl/text_marquee_word_packer.sv
test/text_marquee_word_packer_tb.sv
